/* hdl/mlc_pkg.sv */
// Package: shared types and constants of the metadata lookaside cache.
package mlc_pkg;

  localparam int unsigned ENTRIES    = 128;
  localparam int unsigned IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned VOL_W      = 2;
  localparam int unsigned PAGE_W     = 22;
  localparam int unsigned OFFSET_W   = 13;
  localparam int unsigned SLOT_W     = 7;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned MASK_W     = 8;
  localparam logic [MASK_W-1:0] MASK_RESET = 8'd15;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_PROG   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_VALID = 2'd1,
    ST_INVAL = 2'd2
  } status_t;

  typedef struct packed {
    status_t               status;
    logic [VOL_W-1:0]      volume;
    logic [PAGE_W-1:0]     page;
    logic [OFFSET_W-1:0]   offset;
  } entry_t;

endpackage

/* hdl/mlc_if.sv */
// Interfaces: request and response channels of the metadata lookaside cache.
interface mlc_req_if;
  logic                           valid;
  logic                           ready;
  logic [mlc_pkg::CMD_W-1:0]      cmd;
  logic [mlc_pkg::VOL_W-1:0]      volume_id;
  logic [mlc_pkg::PAGE_W-1:0]     page;
  logic [mlc_pkg::OFFSET_W-1:0]   entry_offset;

  modport source (output valid, cmd, volume_id, page, entry_offset, input ready);
  modport sink   (input valid, cmd, volume_id, page, entry_offset, output ready);
endinterface

interface mlc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [mlc_pkg::SLOT_W-1:0]     slot;
  logic                           invalidated;
  logic [mlc_pkg::COUNT_W-1:0]    access_total;
  logic [mlc_pkg::COUNT_W-1:0]    miss_total;

  modport source (output valid, hit, slot, invalidated, access_total, miss_total,
                  input ready);
  modport sink   (input valid, hit, slot, invalidated, access_total, miss_total,
                  output ready);
endinterface

/* hdl/metadata_lookaside_cache_top.sv */
// Top level: tag store of the metadata lookaside cache with scan sequencer.
//
// Usage:
//   req carries one command per request (lookup, fill, page programmed,
//   clear counters) with volume, page and byte offset; rsp returns exactly
//   one response per request: hit, slot, invalidated and both counters.
//   cfg_we/cfg_wdata write the invalidate page mask (reset value 15); write
//   it only while no request is outstanding.
// Sequencing:
//   One request is worked on at a time. Fill and clear counters need no
//   scan. A lookup reads the tag RAM one entry a cycle from slot 0 and
//   stops at the first empty entry, at a hit or after the last entry. A
//   page programmed request whose page passes the mask reads every entry
//   and writes back matches; otherwise it needs no scan. The single read
//   port of the tag RAM sets the scan rate.
// Reset: all entries read as empty at once (per-entry valid flops), fill
//   pointer and counters go to zero, mask to 15. No clearing pass.
// Stall: the response sits in an output register; the next request is
//   accepted while it waits, and its response waits until rsp drains.
module metadata_lookaside_cache_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [mlc_pkg::MASK_W-1:0]   cfg_wdata,
  mlc_req_if.sink                      req,
  mlc_rsp_if.source                    rsp
);

  localparam int unsigned ENTRY_BITS = $bits(mlc_pkg::entry_t);
  localparam logic [mlc_pkg::IDX_W-1:0] LAST_IDX = mlc_pkg::IDX_W'(mlc_pkg::ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  state_t                          state;
  logic [mlc_pkg::MASK_W-1:0]      inv_mask;
  logic [mlc_pkg::IDX_W-1:0]       fill_ptr;
  logic [mlc_pkg::IDX_W-1:0]       chk_idx;
  logic [mlc_pkg::COUNT_W-1:0]     access_count;
  logic [mlc_pkg::COUNT_W-1:0]     miss_count;
  logic [mlc_pkg::ENTRIES-1:0]     written;
  logic                            rd_live;

  mlc_pkg::cmd_t                   q_cmd;
  logic [mlc_pkg::VOL_W-1:0]       q_vol;
  logic [mlc_pkg::PAGE_W-1:0]      q_page;
  logic [mlc_pkg::OFFSET_W-1:0]    q_offset;

  logic                            res_hit;
  logic [mlc_pkg::SLOT_W-1:0]      res_slot;
  logic                            res_inval;

  logic                            out_valid;
  logic                            out_hit;
  logic [mlc_pkg::SLOT_W-1:0]      out_slot;
  logic                            out_inval;
  logic [mlc_pkg::COUNT_W-1:0]     out_access;
  logic [mlc_pkg::COUNT_W-1:0]     out_miss;

  logic                            accept;
  logic                            load_out;
  mlc_pkg::cmd_t                   in_cmd;
  logic                            mask_ok;
  logic [mlc_pkg::IDX_W-1:0]       rd_addr;
  logic [ENTRY_BITS-1:0]           rd_data;
  mlc_pkg::entry_t                 rd_entry;
  mlc_pkg::status_t                rd_status;
  logic                            page_match;
  logic                            full_match;
  logic                            inv_hit;
  logic                            scan_last;
  logic                            wr_en;
  logic [mlc_pkg::IDX_W-1:0]       wr_addr;
  mlc_pkg::entry_t                 wr_entry;

  // Handshake and request decode
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_cmd    = mlc_pkg::cmd_t'(req.cmd);
  assign mask_ok   = ((req.page[mlc_pkg::MASK_W-1:0] & inv_mask) == inv_mask);

  // Load the response register once the finished result may move in
  assign load_out  = (state == S_FIN) && (!out_valid || rsp.ready);

  // Scan compare on the entry read last cycle; never-written entries read as empty
  assign rd_entry   = mlc_pkg::entry_t'(rd_data);
  assign rd_status  = rd_live ? rd_entry.status : mlc_pkg::ST_EMPTY;
  assign page_match = (rd_entry.volume == q_vol) && (rd_entry.page == q_page);
  assign full_match = (rd_status == mlc_pkg::ST_VALID) && page_match &&
                      (rd_entry.offset == q_offset);
  assign inv_hit    = (rd_status != mlc_pkg::ST_EMPTY) && page_match;
  assign scan_last  = (chk_idx == LAST_IDX);

  // Read the next slot while scanning; slot 0 otherwise, ready for a new scan
  assign rd_addr = (state == S_SCAN) ? mlc_pkg::IDX_W'(chk_idx + 1'b1) : '0;

  // Write port: fill on acceptance, invalidate write-back during a scan
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = fill_ptr;
    wr_entry = '{status: mlc_pkg::ST_VALID, volume: req.volume_id,
                 page: req.page, offset: req.entry_offset};
    if (accept && (in_cmd == mlc_pkg::CMD_FILL)) begin
      wr_en = 1'b1;
    end else if ((state == S_SCAN) && (q_cmd == mlc_pkg::CMD_PROG) && inv_hit) begin
      wr_en    = 1'b1;
      wr_addr  = chk_idx;
      wr_entry = rd_entry;
      wr_entry.status = mlc_pkg::ST_INVAL;
    end
  end

  mlc_tag_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (mlc_pkg::ENTRIES)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Track the written flag alongside the RAM read
  always_ff @(posedge clk) begin
    rd_live <= written[rd_addr];
  end

  // Sequencer, counters and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      inv_mask     <= mlc_pkg::MASK_RESET;
      fill_ptr     <= '0;
      access_count <= '0;
      miss_count   <= '0;
      written      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        inv_mask <= cfg_wdata;
      end
      // Reload or drain the response register
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            q_cmd     <= in_cmd;
            q_vol     <= req.volume_id;
            q_page    <= req.page;
            q_offset  <= req.entry_offset;
            res_hit   <= 1'b0;
            res_slot  <= '0;
            res_inval <= 1'b0;
            chk_idx   <= '0;
            case (in_cmd)
              mlc_pkg::CMD_LOOKUP: begin
                access_count <= access_count + 1'b1;
                state        <= S_SCAN;
              end
              mlc_pkg::CMD_FILL: begin
                res_slot          <= mlc_pkg::SLOT_W'(fill_ptr);
                written[fill_ptr] <= 1'b1;
                fill_ptr          <= (fill_ptr == LAST_IDX) ? '0 :
                                     mlc_pkg::IDX_W'(fill_ptr + 1'b1);
                state             <= S_FIN;
              end
              mlc_pkg::CMD_PROG: begin
                state <= mask_ok ? S_SCAN : S_FIN;
              end
              mlc_pkg::CMD_CLEAR: begin
                access_count <= '0;
                miss_count   <= '0;
                state        <= S_FIN;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (q_cmd == mlc_pkg::CMD_LOOKUP) begin
            // Stop at the first empty entry, at a hit or after the last entry
            if (rd_status == mlc_pkg::ST_EMPTY) begin
              miss_count <= miss_count + 1'b1;
              state      <= S_FIN;
            end else if (full_match) begin
              res_hit  <= 1'b1;
              res_slot <= mlc_pkg::SLOT_W'(chk_idx);
              state    <= S_FIN;
            end else if (scan_last) begin
              miss_count <= miss_count + 1'b1;
              state      <= S_FIN;
            end else begin
              chk_idx <= mlc_pkg::IDX_W'(chk_idx + 1'b1);
            end
          end else begin
            // Invalidate sweep over every entry
            if (inv_hit && (rd_status == mlc_pkg::ST_VALID)) begin
              res_inval <= 1'b1;
            end
            if (scan_last) begin
              state <= S_FIN;
            end else begin
              chk_idx <= mlc_pkg::IDX_W'(chk_idx + 1'b1);
            end
          end
        end
        S_FIN: begin
          // Hold the result until the response register is free
          if (load_out) begin
            out_hit    <= res_hit;
            out_slot   <= res_slot;
            out_inval  <= res_inval;
            out_access <= access_count;
            out_miss   <= miss_count;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.hit          = out_hit;
  assign rsp.slot         = out_slot;
  assign rsp.invalidated  = out_inval;
  assign rsp.access_total = out_access;
  assign rsp.miss_total   = out_miss;

`ifndef NO_ASSERTIONS
  // A lookup counts exactly one access
  a_lookup_counts: assert property (@(posedge clk) disable iff (rst)
    accept && (in_cmd == mlc_pkg::CMD_LOOKUP) |=>
      access_count == $past(access_count) + 1'b1)
    else $error("lookup did not count one access");

  // A response never reports a hit and an invalidation together
  a_hit_inval_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_inval))
    else $error("hit and invalidated both set");

  // A fill advances the round-robin pointer by one, wrapping
  a_fill_advance: assert property (@(posedge clk) disable iff (rst)
    accept && (in_cmd == mlc_pkg::CMD_FILL) |=>
      ($past(fill_ptr) == LAST_IDX) ? (fill_ptr == '0) :
                                      (fill_ptr == $past(fill_ptr) + 1'b1))
    else $error("fill pointer did not advance");

  // Scan write-backs happen only for a page programmed request
  a_scan_write: assert property (@(posedge clk) disable iff (rst)
    wr_en && (state == S_SCAN) |-> (q_cmd == mlc_pkg::CMD_PROG) && inv_hit)
    else $error("unexpected tag write during scan");

  // A completed response cannot overwrite one that is still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready && (state == S_FIN) |=> state == S_FIN)
    else $error("response register overrun");
`endif

endmodule

/* hdl/mlc_tag_ram.sv */
// Simple dual-port tag RAM: one write port, one read port with registered data.
module mlc_tag_ram #(
  parameter int unsigned WIDTH = 39,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
